// File: rtl/krts_pkg.sv
package krts_pkg;

   localparam int CAPACITY_DEF   = 64;
   localparam int NAME_BYTES_DEF = 8;
   localparam int ID_W    = 37;
   localparam int NAME_W  = 64;
   localparam int EXTRA_W = 64;
   localparam int TOTAL_W = 7;
   localparam int REC_W   = ID_W + NAME_W + EXTRA_W;

   typedef enum logic [2:0] {
      KIND_ADD    = 3'd0,
      KIND_SEARCH = 3'd1,
      KIND_DELETE = 3'd2,
      KIND_SET    = 3'd3,
      KIND_SORT   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DUP  = 2'd1,
      ST_MISS = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_SORT_RDI,
      S_SORT_RDJ,
      S_SORT_CMP,
      S_SORT_WRJ,
      S_DONE
   } state_type;

endpackage

// File: rtl/keyed_record_table_with_sort_core.sv
// channel | direction | handshake           | payload
// req     | in        | start && !busy      | req_kind, req_match_id, req_rec_id,
//         |           |                     | req_rec_name, req_rec_extra
// rsp     | out       | rsp_valid (1 cycle) | rsp_status, rsp_found_id, rsp_found_name,
//         |           |                     | rsp_found_extra, rsp_entry_total
//
// records live in one single-port synchronous memory (id, name, extra packed)
// add/search/delete/set: scan reads, then compares, each entry held
// delete: plus a read and a write per entry shifted down and one closing check
// set: the overwrite happens in the compare cycle of the hit, with no extra state
// sort: exchange sort, a read and a compare per (i,j) pair, a write per swap, a row read per row i, quadratic
// reset clears only the state and the entry count; the memory needs no clearing
// busy is high from the accepted item until its result strobe; results cannot stall
module keyed_record_table_with_sort_core #(
   parameter int CAPACITY   = krts_pkg::CAPACITY_DEF,
   parameter int NAME_BYTES = krts_pkg::NAME_BYTES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_kind,
   input  logic [krts_pkg::ID_W-1:0]    req_match_id,
   input  logic [krts_pkg::ID_W-1:0]    req_rec_id,
   input  logic [krts_pkg::NAME_W-1:0]  req_rec_name,
   input  logic [krts_pkg::EXTRA_W-1:0] req_rec_extra,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [krts_pkg::ID_W-1:0]    rsp_found_id,
   output logic [krts_pkg::NAME_W-1:0]  rsp_found_name,
   output logic [krts_pkg::EXTRA_W-1:0] rsp_found_extra,
   output logic [krts_pkg::TOTAL_W-1:0] rsp_entry_total
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = krts_pkg::ID_W;
   localparam int NW = krts_pkg::NAME_W;
   localparam int EW = krts_pkg::EXTRA_W;
   localparam int RW = krts_pkg::REC_W;
   localparam logic [NW-1:0] NAME_MASK = {NW{1'b1}} >> (NW - 8 * NAME_BYTES);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

   // record memory
   logic [RW-1:0] mem [CAPACITY];
   logic [RW-1:0] rd_q;
   logic          we;
   logic [AW-1:0] addr;
   logic [RW-1:0] wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rd_q <= mem[addr];
   end

   logic [IW-1:0] rd_id;
   logic [NW-1:0] rd_name;
   logic [EW-1:0] rd_extra;
   assign rd_id    = rd_q[RW-1 -: IW];
   assign rd_name  = rd_q[NW+EW-1 -: NW];
   assign rd_extra = rd_q[EW-1:0];

   krts_pkg::state_type state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    i_ff, i_in;
   logic [CW-1:0]    j_ff, j_in;
   logic [2:0]       kind_ff, kind_in;
   logic [IW-1:0]    key_ff, key_in;
   logic [RW-1:0]    rec_ff, rec_in;
   logic [RW-1:0]    hold_ff, hold_in;
   logic [1:0]       st_ff, st_in;
   logic [RW-1:0]    found_ff, found_in;

   logic accept;
   assign accept = start && !busy;
   assign busy   = (state_ff != krts_pkg::S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= krts_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      i_ff     <= i_in;
      j_ff     <= j_in;
      kind_ff  <= kind_in;
      key_ff   <= key_in;
      rec_ff   <= rec_in;
      hold_ff  <= hold_in;
      st_ff    <= st_in;
      found_ff <= found_in;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      kind_in  = kind_ff;
      key_in   = key_ff;
      rec_in   = rec_ff;
      hold_in  = hold_ff;
      st_in    = st_ff;
      found_in = found_ff;
      we       = 1'b0;
      addr     = i_ff[AW-1:0];
      wdata    = rec_ff;
      case (state_ff)
         krts_pkg::S_IDLE: begin
            if (accept) begin
               kind_in  = req_kind;
               rec_in   = {req_rec_id, req_rec_name & NAME_MASK, req_rec_extra};
               key_in   = (req_kind == krts_pkg::KIND_ADD) ? req_rec_id : req_match_id;
               st_in    = krts_pkg::ST_OK;
               found_in = '0;
               i_in     = '0;
               case (req_kind)
                  krts_pkg::KIND_ADD, krts_pkg::KIND_SEARCH,
                  krts_pkg::KIND_DELETE, krts_pkg::KIND_SET: begin
                     state_in = krts_pkg::S_SCAN_RD;
                  end
                  krts_pkg::KIND_SORT: begin
                     j_in     = CW'(1);
                     state_in = krts_pkg::S_SORT_RDI;
                  end
                  default: begin
                     state_in = krts_pkg::S_DONE;
                  end
               endcase
            end
         end
         // scan: read entry i, compare next cycle
         krts_pkg::S_SCAN_RD: begin
            if (i_ff >= count_ff) begin
               state_in = krts_pkg::S_DONE;
               if (kind_ff == krts_pkg::KIND_ADD) begin
                  if (count_ff >= CAP_C) begin
                     st_in = krts_pkg::ST_FULL;
                  end else begin
                     we       = 1'b1;
                     addr     = count_ff[AW-1:0];
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  st_in = krts_pkg::ST_MISS;
               end
            end else begin
               state_in = krts_pkg::S_SCAN_CMP;
            end
         end
         krts_pkg::S_SCAN_CMP: begin
            if (rd_id == key_ff) begin
               state_in = krts_pkg::S_DONE;
               case (kind_ff)
                  krts_pkg::KIND_ADD: st_in = krts_pkg::ST_DUP;
                  krts_pkg::KIND_SEARCH: found_in = rd_q;
                  krts_pkg::KIND_SET: we = 1'b1;
                  krts_pkg::KIND_DELETE: begin
                     count_in = count_ff - 1'b1;
                     state_in = krts_pkg::S_SHIFT_RD;
                  end
                  default: ;
               endcase
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = krts_pkg::S_SCAN_RD;
            end
         end
         // delete shift: read i+1, write i; count already decremented
         krts_pkg::S_SHIFT_RD: begin
            if (i_ff >= count_ff) begin
               state_in = krts_pkg::S_DONE;
            end else begin
               addr     = AW'(i_ff + 1'b1);
               state_in = krts_pkg::S_SHIFT_WR;
            end
         end
         krts_pkg::S_SHIFT_WR: begin
            we       = 1'b1;
            wdata    = rd_q;
            i_in     = i_ff + 1'b1;
            state_in = krts_pkg::S_SHIFT_RD;
         end
         // sort: entry i held in hold_ff, entry j read and compared
         krts_pkg::S_SORT_RDI: begin
            if (i_ff + 1'b1 >= count_ff) begin
               state_in = krts_pkg::S_DONE;
            end else begin
               state_in = krts_pkg::S_SORT_RDJ;
            end
         end
         krts_pkg::S_SORT_RDJ: begin
            if (j_ff == i_ff + 1'b1) begin
               hold_in = rd_q;
            end
            addr     = j_ff[AW-1:0];
            state_in = krts_pkg::S_SORT_CMP;
         end
         krts_pkg::S_SORT_CMP: begin
            if (hold_ff[NW+EW-1 -: NW] > rd_name) begin
               we       = 1'b1;
               wdata    = rd_q;
               hold_in  = rd_q;
               rec_in   = hold_ff;
               state_in = krts_pkg::S_SORT_WRJ;
            end else if (j_ff + 1'b1 >= count_ff) begin
               i_in     = i_ff + 1'b1;
               j_in     = i_ff + 2'd2;
               addr     = AW'(i_ff + 1'b1);
               state_in = krts_pkg::S_SORT_RDI;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = krts_pkg::S_SORT_RDJ;
            end
         end
         krts_pkg::S_SORT_WRJ: begin
            we    = 1'b1;
            addr  = j_ff[AW-1:0];
            wdata = rec_ff;
            if (j_ff + 1'b1 >= count_ff) begin
               i_in     = i_ff + 1'b1;
               j_in     = i_ff + 2'd2;
               state_in = krts_pkg::S_SORT_RDI;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = krts_pkg::S_SORT_RDJ;
            end
         end
         krts_pkg::S_DONE: begin
            state_in = krts_pkg::S_IDLE;
         end
         default: begin
            state_in = krts_pkg::S_IDLE;
         end
      endcase
   end

   // the sort read of entry i must land in rd_q before SORT_RDJ captures it
   logic [AW-1:0] rdi_addr;
   assign rdi_addr = i_ff[AW-1:0];

   assign rsp_valid       = (state_ff == krts_pkg::S_DONE);
   assign rsp_status      = st_ff;
   assign rsp_found_id    = found_ff[RW-1 -: IW];
   assign rsp_found_name  = found_ff[NW+EW-1 -: NW];
   assign rsp_found_extra = found_ff[EW-1:0];
   assign rsp_entry_total = krts_pkg::TOTAL_W'(count_ff);

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C) else $error("entry count beyond capacity");
   a_busy_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy) else $error("busy after result");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("not busy after accept");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !busy |=> $stable(count_ff) || busy) else $error("count moved while idle");
   a_sort_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == krts_pkg::S_SORT_RDI) |-> (addr == rdi_addr))
      else $error("sort row read misaddressed");

endmodule
